FILE: rtl/core/wlm_pkg.sv
// ----------------------------------------------------------------------------
// wlm_pkg
// Shared types, constants and helpers for the wildcard line matcher.
// ----------------------------------------------------------------------------
package wlm_pkg;

    localparam int MASK_MAX_DEFAULT = 16;
    localparam int BYTE_W           = 8;
    localparam int CNT_W            = 32;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_INDEX_W      = 2;
    localparam int MASK_LEN_W       = 5;
    localparam int MASK_CHARS_W     = 2 * CFG_DATA_W;

    localparam logic [BYTE_W-1:0] WILDCARD_CHAR = 8'h3F;
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR  = 8'h0A;
    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MASK_CHARS_LOW  = 2'd0,
        REG_MASK_CHARS_HIGH = 2'd1,
        REG_MASK_LENGTH     = 2'd2
    } cfg_reg_t;

    // One text byte handed to the position tracker
    typedef struct packed {
        logic              advance;
        logic [BYTE_W-1:0] text_byte;
    } step_t;

    // Current place in the text
    typedef struct packed {
        logic [CNT_W-1:0] line;
        logic [CNT_W-1:0] column;
    } position_t;

    // A mask character accepts a byte: never a newline, '?' takes anything else
    function automatic logic char_ok(input logic [BYTE_W-1:0] mask_char,
                                     input logic [BYTE_W-1:0] text_char);
        return (text_char != NEWLINE_CHAR) &&
               ((mask_char == WILDCARD_CHAR) || (mask_char == text_char));
    endfunction

endpackage

FILE: rtl/core/wlm_position_tracker.sv
// ----------------------------------------------------------------------------
// wlm_position_tracker
// Recent byte history plus saturating line and column counters.
// ----------------------------------------------------------------------------
module wlm_position_tracker #(
    parameter int MASK_MAX = wlm_pkg::MASK_MAX_DEFAULT,
    localparam int HIST_DEPTH = (MASK_MAX > 1) ? MASK_MAX - 1 : 1
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  wlm_pkg::step_t                              step,
    output wlm_pkg::position_t                          position,
    output logic [HIST_DEPTH-1:0][wlm_pkg::BYTE_W-1:0]  history
);

    logic [HIST_DEPTH-1:0][wlm_pkg::BYTE_W-1:0] history_reg;
    logic [HIST_DEPTH-1:0][wlm_pkg::BYTE_W-1:0] history_next;
    logic [wlm_pkg::CNT_W-1:0] line_reg;
    logic [wlm_pkg::CNT_W-1:0] column_reg;
    logic [wlm_pkg::CNT_W-1:0] line_next;
    logic [wlm_pkg::CNT_W-1:0] column_next;
    logic                      is_newline;

    assign is_newline = (step.text_byte == wlm_pkg::NEWLINE_CHAR);

    always_comb
    begin
        // shift the history, newest byte at the front
        history_next[0] = step.text_byte;
        for (int k = 1; k < HIST_DEPTH; k++)
        begin
            history_next[k] = history_reg[k-1];
        end
        line_next   = line_reg;
        column_next = column_reg;
        if (is_newline)
        begin
            if (line_reg != wlm_pkg::CNT_MAX)
            begin
                line_next = line_reg + 1'b1;
            end
            column_next = '0;
        end
        else if (column_reg != wlm_pkg::CNT_MAX)
        begin
            column_next = column_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
            line_reg    <= '0;
            column_reg  <= '0;
        end
        else if (step.advance)
        begin
            history_reg <= history_next;
            line_reg    <= line_next;
            column_reg  <= column_next;
        end
    end

    assign history         = history_reg;
    assign position.line   = line_reg;
    assign position.column = column_reg;

endmodule

FILE: rtl/core/wlm_window_match.sv
// ----------------------------------------------------------------------------
// wlm_window_match
// Parallel compare of the mask against the newest bytes of the current line.
// ----------------------------------------------------------------------------
module wlm_window_match #(
    parameter int MASK_MAX = wlm_pkg::MASK_MAX_DEFAULT,
    localparam int HIST_DEPTH = (MASK_MAX > 1) ? MASK_MAX - 1 : 1,
    localparam int LEN_W      = $clog2(MASK_MAX + 1)
) (
    input  logic [wlm_pkg::BYTE_W-1:0]                  cur_byte,
    input  logic [HIST_DEPTH-1:0][wlm_pkg::BYTE_W-1:0]  history,
    input  logic [wlm_pkg::MASK_CHARS_W-1:0]            mask_chars,
    input  logic [LEN_W-1:0]                            mask_len,
    input  logic [wlm_pkg::CNT_W-1:0]                   column,
    output logic                                        hit,
    output logic [wlm_pkg::CNT_W-1:0]                   start_column
);

    localparam int IDX_W     = (MASK_MAX > 1) ? $clog2(MASK_MAX) : 1;
    localparam int WIN_DEPTH = 1 << IDX_W;

    // window[0] is the byte in hand, window[j] the byte j places back
    logic [WIN_DEPTH-1:0][wlm_pkg::BYTE_W-1:0] window;
    logic [MASK_MAX-1:0]                       pos_ok;
    logic [LEN_W-1:0]                          len_minus_one;
    logic [LEN_W-1:0]                          win_idx;
    logic                                      window_full;

    assign window[0] = cur_byte;

    genvar j;
    generate
        for (j = 1; j < WIN_DEPTH; j++)
        begin : g_window
            if (j < MASK_MAX)
            begin : g_tap
                assign window[j] = history[j-1];
            end
            else
            begin : g_pad
                assign window[j] = '0;
            end
        end
    endgenerate

    // mask character i lines up with the byte len-1-i places back
    always_comb
    begin
        pos_ok  = '1;
        win_idx = '0;
        for (int i = 0; i < MASK_MAX; i++)
        begin
            if (LEN_W'(i) < mask_len)
            begin
                win_idx   = mask_len - LEN_W'(i) - 1'b1;
                pos_ok[i] = wlm_pkg::char_ok(mask_chars[wlm_pkg::BYTE_W*i +: wlm_pkg::BYTE_W],
                                             window[win_idx[IDX_W-1:0]]);
            end
        end
    end

    assign len_minus_one = mask_len - 1'b1;
    assign window_full   = (column >= wlm_pkg::CNT_W'(len_minus_one));

    assign hit = (mask_len != '0) && (cur_byte != wlm_pkg::NEWLINE_CHAR) &&
                 window_full && (&pos_ok);
    assign start_column = column - wlm_pkg::CNT_W'(len_minus_one);

endmodule

FILE: rtl/core/wildcard_line_matcher_core.sv
// ----------------------------------------------------------------------------
// wildcard_line_matcher_core
// Streams text bytes and reports the line and column of every mask match.
// ----------------------------------------------------------------------------
// Usage:
//   Text enters on text_valid / text_stall / text_byte, one byte per
//   transaction. Each match leaves on match_valid / match_stall with its
//   zero-based start line and column; overlapping matches all come out.
//   The mask is set through cfg_write_enable / cfg_index / cfg_data while
//   the stream is idle: index 0 and 1 load mask characters 0..7 and 8..15,
//   index 2 loads the mask length ('?' matches any byte but newline).
// Timing:
//   A byte goes into the input register on its transaction edge, is compared
//   against the mask and the history while it sits there, and a match lands
//   in the result register when that byte is consumed. One byte per cycle
//   sustained while match_stall stays low.
// Reset:
//   Clears the history, line and column counters, mask characters (to zero)
//   and sets the mask length to 1. No valid is raised until text arrives.
// Stall:
//   A stalled match holds in the result register; the byte in the input
//   register then waits, and text_stall rises once that register is full.
// ----------------------------------------------------------------------------
module wildcard_line_matcher_core #(
    parameter int MASK_MAX = wlm_pkg::MASK_MAX_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write_enable,
    input  logic [wlm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wlm_pkg::CFG_DATA_W-1:0]    cfg_data,
    // text channel
    input  logic                              text_valid,
    output logic                              text_stall,
    input  logic [wlm_pkg::BYTE_W-1:0]        text_byte,
    // match channel
    output logic                              match_valid,
    input  logic                              match_stall,
    output logic [wlm_pkg::CNT_W-1:0]         match_line,
    output logic [wlm_pkg::CNT_W-1:0]         match_column
);

    localparam int HIST_DEPTH = (MASK_MAX > 1) ? MASK_MAX - 1 : 1;
    localparam int LEN_W      = $clog2(MASK_MAX + 1);

    // configuration registers
    logic [wlm_pkg::CFG_DATA_W-1:0] mask_chars_low_reg;
    logic [wlm_pkg::CFG_DATA_W-1:0] mask_chars_high_reg;
    logic [wlm_pkg::MASK_LEN_W-1:0] mask_length_reg;
    logic [LEN_W-1:0]               mask_len;

    // input register
    logic                           in_valid_reg;
    logic [wlm_pkg::BYTE_W-1:0]     in_byte_reg;

    // result register
    logic                           match_valid_reg;
    logic [wlm_pkg::CNT_W-1:0]      match_line_reg;
    logic [wlm_pkg::CNT_W-1:0]      match_column_reg;

    logic                           out_free;
    logic                           advance;
    logic                           hit;
    logic [wlm_pkg::CNT_W-1:0]      start_column;
    wlm_pkg::step_t                 step;
    wlm_pkg::position_t             position;
    logic [HIST_DEPTH-1:0][wlm_pkg::BYTE_W-1:0] history;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_chars_low_reg  <= '0;
            mask_chars_high_reg <= '0;
            mask_length_reg     <= wlm_pkg::MASK_LEN_W'(1);
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                wlm_pkg::REG_MASK_CHARS_LOW:  mask_chars_low_reg  <= cfg_data;
                wlm_pkg::REG_MASK_CHARS_HIGH: mask_chars_high_reg <= cfg_data;
                wlm_pkg::REG_MASK_LENGTH:
                    mask_length_reg <= cfg_data[wlm_pkg::MASK_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Lengths above the mask capacity act as full capacity
    always_comb
    begin
        if (mask_length_reg > wlm_pkg::MASK_LEN_W'(MASK_MAX))
        begin
            mask_len = LEN_W'(MASK_MAX);
        end
        else
        begin
            mask_len = mask_length_reg[LEN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the input register drains whenever the result register
    // is empty or its match is being taken this cycle
    // ------------------------------------------------------------------
    assign out_free   = !match_valid_reg || !match_stall;
    assign advance    = in_valid_reg && out_free;
    assign text_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            in_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall && text_valid)
        begin
            in_byte_reg <= text_byte;
        end
    end

    // ------------------------------------------------------------------
    // Position and history; advance once per consumed byte
    // ------------------------------------------------------------------
    assign step.advance   = advance;
    assign step.text_byte = in_byte_reg;

    wlm_position_tracker #(
        .MASK_MAX (MASK_MAX)
    ) u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .position (position),
        .history  (history)
    );

    wlm_window_match #(
        .MASK_MAX (MASK_MAX)
    ) u_match (
        .cur_byte     (in_byte_reg),
        .history      (history),
        .mask_chars   ({mask_chars_high_reg, mask_chars_low_reg}),
        .mask_len     (mask_len),
        .column       (position.column),
        .hit          (hit),
        .start_column (start_column)
    );

    // ------------------------------------------------------------------
    // Result register: load a match, hold it while stalled
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            match_valid_reg <= advance && hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hit)
        begin
            match_line_reg   <= position.line;
            match_column_reg <= start_column;
        end
    end

    assign match_valid  = match_valid_reg;
    assign match_line   = match_line_reg;
    assign match_column = match_column_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_newline_never_hits : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_byte_reg == wlm_pkg::NEWLINE_CHAR)) |-> !hit)
        else $error("newline byte reported as a match");

    a_newline_clears_column : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_byte_reg == wlm_pkg::NEWLINE_CHAR)) |=> (position.column == '0))
        else $error("column not cleared after newline");

    a_column_steps : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_byte_reg != wlm_pkg::NEWLINE_CHAR) &&
         (position.column != wlm_pkg::CNT_MAX))
        |=> (position.column == $past(position.column) + 1'b1))
        else $error("column did not advance on a text byte");

    a_match_from_byte : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(match_valid_reg) |-> $past(advance && hit))
        else $error("match raised without a consumed byte");

    a_stall_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> (in_valid_reg && match_valid_reg))
        else $error("text stalled with room in the pipeline");

endmodule

FILE: bench/wildcard_line_matcher_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_line_matcher_core_test
// Self-checking bench for the streaming wildcard line matcher.
// A short table of directed transactions comes first: reset mask, zero and
// oversized mask length, wildcard against newline, overlapping hits and a
// newline inside the mask. Random phases follow, each with a new mask and
// text built mostly from planted mask copies. Every match is checked against
// an in-bench scanner that tracks history, line and column, or a typed outcome.
// ----------------------------------------------------------------------------
module wildcard_line_matcher_core_test;
    import wlm_pkg::*;

    localparam int MASK_MAX        = MASK_MAX_DEFAULT;
    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 118;
    localparam int HOLD_PHASE      = 6;
    localparam int PAUSE_PHASE     = 9;
    localparam int ALL_ONES_PHASE  = 7;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PRINT_CAP       = 50;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum int {ROW_CFG, ROW_TEXT} row_kind_e;
    // How a directed text row is checked: by the scanner, or by a typed outcome
    typedef enum int {CHECK_MODEL, CHECK_HIT, CHECK_MISS} row_check_e;

    typedef struct {
        logic [CNT_W-1:0] line;
        logic [CNT_W-1:0] column;
    } match_pos_t;

    typedef struct {
        row_kind_e              kind;
        cfg_reg_t               reg_idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [BYTE_W-1:0]      text;
        row_check_e             check;
        match_pos_t             pos;
    } dir_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write_enable;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    text_valid;
    logic                    text_stall;
    logic [BYTE_W-1:0]       text_byte;
    logic                    match_valid;
    logic                    match_stall;
    logic [CNT_W-1:0]        match_line;
    logic [CNT_W-1:0]        match_column;

    // Scanner state: mask registers, last bytes (newest first), position
    logic [CFG_DATA_W-1:0]   mask_lo;
    logic [CFG_DATA_W-1:0]   mask_hi;
    logic [MASK_LEN_W-1:0]   mask_len;
    logic [BYTE_W-1:0]       history [MASK_MAX-1];
    logic [CNT_W-1:0]        cur_line;
    logic [CNT_W-1:0]        cur_col;

    match_pos_t  pending_matches[$];
    dir_row_t    directed_rows[$];
    idle_mode_e  idle_mode;
    int          mismatch_count;
    int          bytes_sent;
    int          matches_seen;
    int          reg_writes;
    int          hold_requests;
    int          holds_served;

    wildcard_line_matcher_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .text_valid       (text_valid),
        .text_stall       (text_stall),
        .text_byte        (text_byte),
        .match_valid      (match_valid),
        .match_stall      (match_stall),
        .match_line       (match_line),
        .match_column     (match_column)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #(64'd5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Print one line per mismatch; keep counting once the print cap is reached
    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [BYTE_W-1:0] mask_at(input int i);
        if (i < 8)
            return mask_lo[8*i +: 8];
        return mask_hi[8*(i-8) +: 8];
    endfunction

    // A mask character takes a text byte: wildcard takes anything but newline
    function automatic bit byte_fits(input logic [BYTE_W-1:0] m, input logic [BYTE_W-1:0] b);
        if (b == NEWLINE_CHAR)
            return 1'b0;
        return (m == WILDCARD_CHAR) || (m == b);
    endfunction

    // Advance the scanner by one text byte; report whether a match ends here
    task automatic scan_byte(input logic [BYTE_W-1:0] b, output bit hit,
                             output match_pos_t pos);
        int eff;
        int i;
        hit        = 1'b0;
        pos.line   = cur_line;
        pos.column = '0;
        // Lengths above the window size behave as a full window
        eff = (mask_len > MASK_MAX) ? MASK_MAX : int'(mask_len);
        if (b != NEWLINE_CHAR && eff > 0 && cur_col >= 32'(eff - 1))
        begin
            hit = byte_fits(mask_at(eff - 1), b);
            for (i = 0; i < eff - 1; i++)
            begin
                if (!byte_fits(mask_at(i), history[eff - 2 - i]))
                    hit = 1'b0;
            end
        end
        pos.column = cur_col - 32'(eff - 1);
        for (i = MASK_MAX - 2; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = b;
        if (b == NEWLINE_CHAR)
        begin
            if (cur_line != CNT_MAX)
                cur_line++;
            cur_col = '0;
        end
        else if (cur_col != CNT_MAX)
        begin
            cur_col++;
        end
    endtask

    // Offer one byte, hold it until accepted, then log what it should produce
    task automatic push_text(input logic [BYTE_W-1:0] b, input row_check_e check,
                             input match_pos_t typed);
        bit         hit;
        match_pos_t pos;
        while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 65) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 25))
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        scan_byte(b, hit, pos);
        bytes_sent++;
        case (check)
            CHECK_HIT:  pending_matches.push_back(typed);
            CHECK_MISS: ;
            default:    if (hit) pending_matches.push_back(pos);
        endcase
    endtask

    // Drop valid, let every expected match drain, then give the pipe time to empty
    task automatic wait_idle();
        int waited;
        text_valid <= 1'b0;
        waited = 0;
        while (pending_matches.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_matches.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected matches never arrived",
                                      pending_matches.size()));
            pending_matches.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= data;
        @(posedge clk);
        case (idx)
            REG_MASK_CHARS_LOW:  mask_lo  = data;
            REG_MASK_CHARS_HIGH: mask_hi  = data;
            REG_MASK_LENGTH:     mask_len = data[MASK_LEN_W-1:0];
            default:             ;
        endcase
        reg_writes++;
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row.kind       = ROW_CFG;
        row.reg_idx    = idx;
        row.data       = data;
        row.text       = '0;
        row.check      = CHECK_MODEL;
        row.pos.line   = '0;
        row.pos.column = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_text(input logic [BYTE_W-1:0] b, input row_check_e check,
                            input int line, input int column);
        dir_row_t row;
        row.kind       = ROW_TEXT;
        row.reg_idx    = REG_MASK_CHARS_LOW;
        row.data       = '0;
        row.text       = b;
        row.check      = check;
        row.pos.line   = 32'(line);
        row.pos.column = 32'(column);
        directed_rows.push_back(row);
    endtask

    // Match side: check each transaction against the oldest expectation and
    // choose the stall for the next cycle (random, or a long counted hold)
    initial
    begin
        int         hold_left;
        int         roll;
        match_pos_t exp_pos;
        hold_left   = 0;
        match_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (match_valid && !match_stall)
            begin
                matches_seen++;
                if (pending_matches.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected match at line %0d column %0d",
                                              match_line, match_column));
                end
                else
                begin
                    exp_pos = pending_matches.pop_front();
                    if (match_line !== exp_pos.line)
                        report_mismatch($sformatf("match_line %0d, expected %0d",
                                                  match_line, exp_pos.line));
                    if (match_column !== exp_pos.column)
                        report_mismatch($sformatf("match_column %0d, expected %0d",
                                                  match_column, exp_pos.column));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (hold_requests != holds_served)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            roll = $urandom_range(99);
            match_stall <= (hold_left > 0) ||
                           (idle_mode == IDLE_RECEIVER && roll < 65) ||
                           (idle_mode == IDLE_BOTH && roll < 25);
        end
    end

    initial
    begin
        int                     phase;
        int                     i;
        int                     roll;
        int                     eff;
        logic [MASK_LEN_W-1:0]  len;
        logic [BYTE_W-1:0]      c;
        logic [CFG_DATA_W-1:0]  lo;
        logic [CFG_DATA_W-1:0]  hi;
        logic [CFG_DATA_W-1:0]  junk;
        logic [BYTE_W-1:0]      text_q[$];
        match_pos_t             no_pos;

        // Hold every input at a known value from time zero
        rst_n            <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_index        <= REG_MASK_CHARS_LOW;
        cfg_data         <= '0;
        text_valid       <= 1'b0;
        text_byte        <= '0;
        idle_mode        = IDLE_NONE;
        mismatch_count   = 0;
        bytes_sent       = 0;
        matches_seen     = 0;
        reg_writes       = 0;
        hold_requests    = 0;
        holds_served     = 0;
        no_pos.line      = '0;
        no_pos.column    = '0;

        // Scanner starts from the reset state: one NUL mask character
        mask_lo  = '0;
        mask_hi  = '0;
        mask_len = MASK_LEN_W'(1);
        cur_line = '0;
        cur_col  = '0;
        for (i = 0; i < MASK_MAX - 1; i++)
            history[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed table ----------------
        // Reset mask is a single NUL: matches only byte 0
        add_text(8'h00, CHECK_HIT, 0, 0);
        add_text(8'hFF, CHECK_MISS, 0, 0);
        add_text(NEWLINE_CHAR, CHECK_MISS, 0, 0);
        // Zero length never matches; upper data bits are ignored
        add_cfg(REG_MASK_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
        add_text(8'h00, CHECK_MISS, 0, 0);
        // Single wildcard: skips newline, takes any other byte, '?' included
        add_cfg(REG_MASK_CHARS_LOW, 64'h3F);
        add_cfg(REG_MASK_LENGTH, 64'h1);
        add_text(NEWLINE_CHAR, CHECK_MISS, 0, 0);
        add_text(8'hFF, CHECK_HIT, 2, 0);
        add_text(WILDCARD_CHAR, CHECK_HIT, 2, 1);
        // "a?c" then overlapping hits on "aacc"
        add_cfg(REG_MASK_CHARS_LOW, 64'h0063_3F61);
        add_cfg(REG_MASK_LENGTH, 64'h3);
        add_text(8'h61, CHECK_MODEL, 0, 0);
        add_text(8'h78, CHECK_MODEL, 0, 0);
        add_text(8'h63, CHECK_HIT, 2, 2);
        add_text(8'h61, CHECK_MODEL, 0, 0);
        add_text(8'h61, CHECK_MODEL, 0, 0);
        add_text(8'h63, CHECK_MODEL, 0, 0);
        add_text(8'h63, CHECK_MODEL, 0, 0);
        // Length 31 acts as a full 16-wide window of wildcards
        add_cfg(REG_MASK_CHARS_LOW, {8{WILDCARD_CHAR}});
        add_cfg(REG_MASK_CHARS_HIGH, {8{WILDCARD_CHAR}});
        add_cfg(REG_MASK_LENGTH, 64'h1F);
        add_text(8'h00, CHECK_MISS, 0, 0);
        add_text(8'hFF, CHECK_MISS, 0, 0);
        add_text(8'h80, CHECK_MISS, 0, 0);
        add_text(8'h7F, CHECK_MISS, 0, 0);
        add_text(8'h01, CHECK_MISS, 0, 0);
        add_text(8'hFE, CHECK_MISS, 0, 0);
        add_text(8'h3F, CHECK_HIT, 2, 0);
        add_text(8'h20, CHECK_HIT, 2, 1);
        // Newline inside the mask can never be satisfied
        add_cfg(REG_MASK_CHARS_LOW, 64'h0A61);
        add_cfg(REG_MASK_LENGTH, 64'h2);
        add_text(8'h61, CHECK_MISS, 0, 0);
        add_text(NEWLINE_CHAR, CHECK_MISS, 0, 0);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].data);
            end
            else
            begin
                push_text(directed_rows[r].text, directed_rows[r].check,
                          directed_rows[r].pos);
            end
        end
        wait_idle();

        // ---------------- random phases ----------------
        for (phase = 0; phase < PHASES; phase++)
        begin
            idle_mode = idle_mode_e'(phase % 4);
            // Keep the sender busy while the receiver is held off
            if (phase == HOLD_PHASE)
                idle_mode = IDLE_NONE;

            case (phase)
                0:       len = MASK_LEN_W'(16);
                1:       len = MASK_LEN_W'(1);
                2:       len = MASK_LEN_W'(31);
                3:       len = MASK_LEN_W'(0);
                4:       len = MASK_LEN_W'(17);
                default: len = MASK_LEN_W'($urandom_range(2, 16));
            endcase

            // Mask drawn from a small alphabet so planted copies line up often
            for (i = 0; i < MASK_MAX; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 45)
                    c = WILDCARD_CHAR;
                else if (roll < 90)
                    c = 8'h61 + BYTE_W'($urandom_range(2));
                else if (roll < 98)
                    c = BYTE_W'($urandom_range(255));
                else
                    c = NEWLINE_CHAR;
                if (i < 8)
                    lo[8*i +: 8] = c;
                else
                    hi[8*(i-8) +: 8] = c;
            end
            if (phase == ALL_ONES_PHASE)
            begin
                lo = '1;
                hi = '1;
            end
            junk = {$urandom, $urandom};
            junk[MASK_LEN_W-1:0] = len;

            wait_idle();
            write_reg(REG_MASK_CHARS_LOW, lo);
            write_reg(REG_MASK_CHARS_HIGH, hi);
            write_reg(REG_MASK_LENGTH, junk);

            // Build the text: planted mask copies with random fill, plus noise
            eff = (len > MASK_MAX) ? MASK_MAX : int'(len);
            text_q.delete();
            while (text_q.size() < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(1) == 1 && eff > 0)
                begin
                    for (i = 0; i < eff; i++)
                    begin
                        c = mask_at(i);
                        if (c == WILDCARD_CHAR)
                        begin
                            roll = $urandom_range(99);
                            if (roll < 50)
                                c = 8'h61 + BYTE_W'($urandom_range(2));
                            else if (roll < 90)
                                c = BYTE_W'($urandom_range(255));
                        end
                        // Break a copy now and then
                        if ($urandom_range(99) < 8)
                            c = BYTE_W'($urandom_range(255));
                        text_q.push_back(c);
                    end
                end
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 40)
                        c = 8'h61 + BYTE_W'($urandom_range(2));
                    else if (roll < 85)
                        c = BYTE_W'($urandom_range(255));
                    else
                        c = NEWLINE_CHAR;
                    text_q.push_back(c);
                end
            end

            for (i = 0; i < text_q.size(); i++)
            begin
                // Long receiver hold while bytes keep coming: fills the pipe
                if (phase == HOLD_PHASE && i == 10)
                    hold_requests++;
                // Sender pause until every pending match has come out
                if (phase == PAUSE_PHASE && i == text_q.size() / 2)
                    wait_idle();
                push_text(text_q[i], CHECK_MODEL, no_pos);
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);

        $display("Summary: %0d text bytes, %0d matches checked, %0d register writes",
                 bytes_sent, matches_seen, reg_writes);
        $display("Summary: mask lengths 0, 1, 16, 17, 31 and random; four idling patterns");
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/wlm_pkg.sv
rtl/core/wlm_position_tracker.sv
rtl/core/wlm_window_match.sv
rtl/core/wildcard_line_matcher_core.sv
bench/wildcard_line_matcher_core_test.sv
